FILE: design/banfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banfs_pkg: shared types and constants
// Register map, configuration bundle, sequencer states and the fixed field
// widths of the boundary area sum block.
// ----------------------------------------------------------------------------
package banfs_pkg;

	localparam int SUM_BITS_DEF = 40;

	localparam int FRAC_W = 16;          // face fraction, boundary area, normals
	localparam int D_W    = FRAC_W + 1;  // fraction difference
	localparam int CFA_W  = 24;          // cell face area
	localparam int MUL_W  = 25;          // shared multiplier operand
	localparam int Q_W    = 34;          // squared normal length
	localparam int L_W    = 32;          // root of Q * 2^30
	localparam int MAG_W  = 33;          // |dot sum|
	localparam int QUO_W  = 17;          // dot quotient
	localparam int DOT_W  = 19;          // signed dot and its bounds
	localparam int SUB_W  = 64;          // shared subtractor
	localparam int CNT_W  = 6;
	localparam int OUT_W  = 64;

	localparam int MAC_STEPS  = 3;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = QUO_W;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic signed [DOT_W-1:0] NEG_ONE = -19'sd32768;

	typedef enum logic [2:0] {
		REG_CHECK = 3'd0,
		REG_NX    = 3'd1,
		REG_NY    = 3'd2,
		REG_NZ    = 3'd3,
		REG_TOL   = 3'd4,
		REG_CFA   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic                     check_normal;
		logic signed [FRAC_W-1:0] normal_x;
		logic signed [FRAC_W-1:0] normal_y;
		logic signed [FRAC_W-1:0] normal_z;
		logic [FRAC_W-1:0]        tolerance;
		logic [CFA_W-1:0]         cell_face_area;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC_Q,
		ST_MAC_S,
		ST_SQRT,
		ST_DIV_LOAD,
		ST_DIV,
		ST_TEST,
		ST_ACCUM,
		ST_PLOAD,
		ST_PROD,
		ST_OUT
	} st_t;

endpackage

FILE: design/banfs_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banfs_apb: configuration register file
// APB-style slave holding the six configuration registers; zero wait states.
// ----------------------------------------------------------------------------
module banfs_apb
	import banfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_CHECK: begin
					cfg_q.check_normal <= pwdata[0];
				end
				REG_NX: begin
					cfg_q.normal_x <= pwdata[FRAC_W-1:0];
				end
				REG_NY: begin
					cfg_q.normal_y <= pwdata[FRAC_W-1:0];
				end
				REG_NZ: begin
					cfg_q.normal_z <= pwdata[FRAC_W-1:0];
				end
				REG_TOL: begin
					cfg_q.tolerance <= pwdata[FRAC_W-1:0];
				end
				REG_CFA: begin
					cfg_q.cell_face_area <= pwdata[CFA_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CHECK: prdata = DATA_W'(cfg_q.check_normal);
			REG_NX:    prdata = DATA_W'(unsigned'(cfg_q.normal_x));
			REG_NY:    prdata = DATA_W'(unsigned'(cfg_q.normal_y));
			REG_NZ:    prdata = DATA_W'(unsigned'(cfg_q.normal_z));
			REG_TOL:   prdata = DATA_W'(cfg_q.tolerance);
			REG_CFA:   prdata = DATA_W'(cfg_q.cell_face_area);
			default:   prdata = '0;
		endcase
	end

endmodule

FILE: design/boundary_area_normal_filter_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_area_normal_filter_sum: filtered embedded-boundary area sum
// Sums the boundary area of cut cells, optionally keeping only cells whose
// unit normal lies against a target normal, and returns the scaled sum on the
// last cell of a run.
// ----------------------------------------------------------------------------
// One cell is taken per transfer on the input channel; in_stall is high for
// as long as the cell is being worked on. A cell that is uncut, or any cell
// while check_normal is 0, goes straight to the add into the sum. A cut cell
// with checking on runs 3 + 3 multiply-accumulate steps for |d|^2 and d.n on
// one shared multiplier (a zero-length normal then skips to the add), 32 one-bit
// square root steps and 17 one-bit divide steps that share one 64-bit
// subtractor, then a test and the add into the sum. A cell marked last then
// forms the sum times cell_face_area product 24 bits at a time on the same
// multiplier, in NCHUNK chunks (NCHUNK = ceil(SUM_BITS / 24), 2 at the
// default), and waits while the output register holds an untaken total. The result
// sits in an output register, so the next cell is taken while a finished
// total still waits for its transfer. Configuration goes through the APB-style
// port and must only change while the block is idle.
// ----------------------------------------------------------------------------
module boundary_area_normal_filter_sum
	import banfs_pkg::*;
#(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// cell input
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cut_cell,
	input  logic [FRAC_W-1:0] boundary_area,
	input  logic [FRAC_W-1:0] frac_x_low,
	input  logic [FRAC_W-1:0] frac_x_high,
	input  logic [FRAC_W-1:0] frac_y_low,
	input  logic [FRAC_W-1:0] frac_y_high,
	input  logic [FRAC_W-1:0] frac_z_low,
	input  logic [FRAC_W-1:0] frac_z_high,
	input  logic              last_cell,
	// result
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OUT_W-1:0]  total_area
);

	// accumulator: holds |d|^2, d.n and the Horner product sum * cfa
	localparam int ACC_W  = (SUM_BITS + MUL_W > 2 * MUL_W) ? SUM_BITS + MUL_W : 2 * MUL_W;
	localparam int NCHUNK = (SUM_BITS + CFA_W - 1) / CFA_W;
	localparam int SH_W   = NCHUNK * CFA_W;

	cfg_t cfg;

	banfs_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	st_t                      state_q, state_d;
	logic [CNT_W-1:0]         cnt_q;
	logic                     accept;
	logic                     out_free;
	logic                     out_load;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         total_q;
	logic [SUM_BITS-1:0]      area_sum_q;

	logic                     last_q;
	logic                     keep_q;     // add this cell's area
	logic [FRAC_W-1:0]        area_in_q;
	logic signed [D_W-1:0]    dx_q, dy_q, dz_q;

	logic signed [ACC_W-1:0]  acc_q;
	logic [Q_W-1:0]           qsq_q;
	logic [SUB_W-1:0]         v_q, res_q, bit_q;
	logic                     s_neg_q;
	logic [MAG_W-1:0]         rem_q;
	logic [MAG_W-1:0]         dvs_q;
	logic [QUO_W-1:0]         nlo_q;
	logic [QUO_W-1:0]         quo_q;
	logic [SH_W-1:0]          sh_q;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic mac_last, sqrt_last, div_last, prod_last;

	assign mac_last  = (cnt_q == CNT_W'(MAC_STEPS - 1));
	assign sqrt_last = (cnt_q == CNT_W'(SQRT_STEPS - 1));
	assign div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign prod_last = (cnt_q == CNT_W'(NCHUNK - 1));
	assign out_free  = ~out_valid_q | ~out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (cut_cell & cfg.check_normal) ? ST_MAC_Q : ST_ACCUM;
				end
			end
			ST_MAC_Q: begin
				if (mac_last) state_d = ST_MAC_S;
			end
			ST_MAC_S: begin
				// zero-length normal never passes
				if (mac_last) state_d = (qsq_q == '0) ? ST_ACCUM : ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_last) state_d = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) state_d = ST_TEST;
			end
			ST_TEST: begin
				state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				state_d = last_q ? ST_PLOAD : ST_IDLE;
			end
			ST_PLOAD: begin
				state_d = ST_PROD;
			end
			ST_PROD: begin
				if (prod_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = (state_q == ST_OUT) & out_free;
	end

	assign accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Shared multiplier, multiply-accumulate
	// ------------------------------------------------------------------
	logic signed [D_W-1:0]      d_sel;
	logic signed [FRAC_W-1:0]   n_sel;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [2*MUL_W-1:0]  prod;
	logic signed [ACC_W-1:0]    acc_base, acc_next;
	logic                       mac_en;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				d_sel = dx_q;
				n_sel = cfg.normal_x;
			end
			2'd1: begin
				d_sel = dy_q;
				n_sel = cfg.normal_y;
			end
			default: begin
				d_sel = dz_q;
				n_sel = cfg.normal_z;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_MAC_Q: begin
				mul_a = MUL_W'(d_sel);
				mul_b = MUL_W'(d_sel);
			end
			ST_MAC_S: begin
				mul_a = MUL_W'(d_sel);
				mul_b = MUL_W'(n_sel);
			end
			ST_PROD: begin
				mul_a = signed'({1'b0, sh_q[SH_W-1 -: CFA_W]});
				mul_b = signed'({1'b0, cfg.cell_face_area});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign acc_base = (state_q == ST_PROD) ? (acc_q <<< CFA_W) : acc_q;
	assign acc_next = acc_base + ACC_W'(prod);
	assign mac_en   = (state_q inside {ST_MAC_Q, ST_MAC_S, ST_PROD});

	// ------------------------------------------------------------------
	// Shared subtractor: root and divide steps
	// ------------------------------------------------------------------
	logic [SUB_W-1:0]  sub_a, sub_b;
	logic [SUB_W:0]    diff;
	logic              ge;
	logic [MAG_W:0]    div_t;
	logic              in_sqrt;

	assign in_sqrt = (state_q == ST_SQRT);
	assign div_t   = {rem_q, nlo_q[QUO_W-1]};
	// root and bit never overlap, so OR is the trial sum
	assign sub_a   = in_sqrt ? v_q : SUB_W'(div_t);
	assign sub_b   = in_sqrt ? (res_q | bit_q) : SUB_W'(dvs_q);
	assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge      = ~diff[SUB_W];

	// ------------------------------------------------------------------
	// Divide set-up and dot test
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0]  acc_abs;
	logic [MAG_W+FRAC_W:0]    numer;
	logic signed [DOT_W-1:0]  dot, lo_bound, hi_bound;
	logic                     pass;

	assign acc_abs  = acc_q[ACC_W-1] ? -acc_q : acc_q;
	// (|S| << 16) + L, divided by 2L gives the rounded |dot|
	assign numer    = {1'b0, acc_abs[MAG_W-1:0], {FRAC_W{1'b0}}}
			+ (MAG_W + FRAC_W + 1)'(res_q[L_W-1:0]);
	assign dot      = s_neg_q ? -signed'({2'b00, quo_q}) : signed'({2'b00, quo_q});
	assign lo_bound = NEG_ONE - signed'({3'b000, cfg.tolerance});
	assign hi_bound = NEG_ONE + signed'({3'b000, cfg.tolerance});
	assign pass     = (lo_bound <= dot) & (dot <= hi_bound);

	// ------------------------------------------------------------------
	// Sum and product
	// ------------------------------------------------------------------
	logic [SUM_BITS:0]  sum_ext;
	logic [127:0]       acc_wide;
	logic               sat;

	assign sum_ext  = {1'b0, area_sum_q} + (SUM_BITS + 1)'(keep_q ? area_in_q : '0);
	assign acc_wide = 128'(acc_q);
	assign sat      = |acc_wide[127:OUT_W];

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			area_in_q <= boundary_area;
			last_q    <= last_cell;
			keep_q    <= cut_cell & ~cfg.check_normal;
			dx_q      <= signed'({1'b0, frac_x_low}) - signed'({1'b0, frac_x_high});
			dy_q      <= signed'({1'b0, frac_y_low}) - signed'({1'b0, frac_y_high});
			dz_q      <= signed'({1'b0, frac_z_low}) - signed'({1'b0, frac_z_high});
			acc_q     <= '0;
		end

		// |d|^2 is parked in qsq_q and the accumulator cleared for d.n
		if (mac_en) begin
			acc_q <= (state_q == ST_MAC_Q && mac_last) ? '0 : acc_next;
		end
		if (state_q == ST_MAC_Q && mac_last) begin
			qsq_q <= acc_next[Q_W-1:0];
		end
		if (state_q == ST_MAC_S && mac_last) begin
			v_q   <= {qsq_q, {(SUB_W - Q_W){1'b0}}};
			res_q <= '0;
			bit_q <= {2'b01, {(SUB_W - 2){1'b0}}};
		end

		if (state_q == ST_SQRT) begin
			if (ge) begin
				v_q   <= diff[SUB_W-1:0];
				res_q <= (res_q >> 1) | bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (state_q == ST_DIV_LOAD) begin
			s_neg_q <= acc_q[ACC_W-1];
			rem_q   <= numer[MAG_W+FRAC_W -: MAG_W];
			nlo_q   <= numer[QUO_W-1:0];
			dvs_q   <= {res_q[L_W-1:0], 1'b0};
			quo_q   <= '0;
		end

		if (state_q == ST_DIV) begin
			if (ge) begin
				rem_q <= diff[MAG_W-1:0];
			end else begin
				rem_q <= div_t[MAG_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			nlo_q <= nlo_q << 1;
		end

		if (state_q == ST_TEST) begin
			keep_q <= pass;
		end

		if (state_q == ST_PLOAD) begin
			sh_q  <= SH_W'(area_sum_q);
			acc_q <= '0;
		end
		if (state_q == ST_PROD) begin
			sh_q <= sh_q << CFA_W;
		end

		if (out_load) begin
			total_q <= sat ? '1 : acc_wide[OUT_W-1:0];
		end
	end

	// running sum and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_sum_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_ACCUM) begin
				area_sum_q <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
			end else if (state_q == ST_PLOAD) begin
				area_sum_q <= '0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign total_area = total_q;

endmodule

FILE: design/banfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banfs_checker: port-level checks
// Watches the cell and result channels of the boundary area sum block.
// ----------------------------------------------------------------------------
module banfs_checker
	import banfs_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             cut_cell,
	input logic             last_cell,
	input logic             out_valid,
	input logic             out_stall,
	input logic [OUT_W-1:0] total_area
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(total_area))
		else $error("result changed while stalled");

	// a cell transfer always makes the block busy
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("not busy after cell transfer");

	// an uncut, non-last cell frees the input once its add into the sum is done
	a_fast_cell: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !cut_cell && !last_cell |-> ##2 !in_stall)
		else $error("uncut cell held the input too long");

	// a result appears only at the end of work on a cell
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while idle");

endmodule

bind boundary_area_normal_filter_sum banfs_checker u_banfs_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: boundary_area_normal_filter_sum
// Feeds grid cells with random gaps and keeps its own fixed-point model of
// the normal filter and the area sum. Each total_area transfer is checked
// against the model. Registers are rewritten between phases and read back.
// ----------------------------------------------------------------------------
module testbench;
	import banfs_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 10;
	localparam int SUM_W         = SUM_BITS_DEF;
	// covers the slowest cell, plus the product and the output register
	localparam int DRAIN_CYCLES  = 120;
	localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
	localparam int IDLE_LIMIT    = 4000;   // cycles without any transfer
	localparam int SPARE_LO      = 6;      // unused register slots
	localparam int SPARE_HI      = 7;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_CELLS   = 100;
	localparam int BURST_CELLS   = 50;
	localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;

	typedef struct packed {
		logic              cut;
		logic [FRAC_W-1:0] area;
		logic [FRAC_W-1:0] x_lo;
		logic [FRAC_W-1:0] x_hi;
		logic [FRAC_W-1:0] y_lo;
		logic [FRAC_W-1:0] y_hi;
		logic [FRAC_W-1:0] z_lo;
		logic [FRAC_W-1:0] z_hi;
		logic              last;
	} cell_t;

	// ------------------------------------------------------------------
	// DUT connections, every input known from time zero
	// ------------------------------------------------------------------
	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	cell_t             cell_q   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [OUT_W-1:0]  total_area;

	// ------------------------------------------------------------------
	// model state and bookkeeping
	// ------------------------------------------------------------------
	cfg_t              cfg_now       = '0;
	longint unsigned   area_sum_now  = 0;
	cell_t             cells_pending[$];
	logic [OUT_W-1:0]  totals_due[$];
	logic [OUT_W-1:0]  want;

	int send_gap    = 0;
	int stall_run   = 0;
	int hold_cnt    = 0;
	bit quiet       = 1'b0;   // no random idle gaps on either side while set
	bit hold_req    = 1'b0;
	bit hold_done   = 1'b0;
	int idle_cycles = 0;

	int errors     = 0;
	int n_cells    = 0;
	int n_summed   = 0;
	int n_dropped  = 0;
	int n_totals   = 0;
	int n_settings = 0;

	always #HALF_PERIOD clk = ~clk;

	boundary_area_normal_filter_sum #(
		.SUM_BITS(SUM_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cut_cell     (cell_q.cut),
		.boundary_area(cell_q.area),
		.frac_x_low   (cell_q.x_lo),
		.frac_x_high  (cell_q.x_hi),
		.frac_y_low   (cell_q.y_lo),
		.frac_y_high  (cell_q.y_hi),
		.frac_z_low   (cell_q.z_lo),
		.frac_z_high  (cell_q.z_hi),
		.last_cell    (cell_q.last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.total_area   (total_area)
	);

	// ------------------------------------------------------------------
	// idle lengths: mostly none or short, now and then a long one
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// bitwise integer square root, floor
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res  = 0;
		longint unsigned step = 64'h4000_0000_0000_0000;
		while (step > v)
			step >>= 2;
		while (step != 0) begin
			if (v >= res + step) begin
				v  -= res + step;
				res = (res >> 1) + step;
			end else begin
				res >>= 1;
			end
			step >>= 2;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Normal test. d = low - high per axis in 2^-15 units, the length is
	// taken as floor(sqrt(|d|^2 * 2^30)), and the dot product with the target
	// is rounded half away from zero to Q.15. The cell is kept when the dot
	// lies within tolerance of -1. A zero-length normal never passes.
	// ------------------------------------------------------------------
	function automatic bit faces_oppose_target(cell_t c);
		longint dx, dy, dz, s, dot, lo, hi;
		longint unsigned q, len, mag, qm;
		dx = longint'(c.x_lo) - longint'(c.x_hi);
		dy = longint'(c.y_lo) - longint'(c.y_hi);
		dz = longint'(c.z_lo) - longint'(c.z_hi);
		q  = dx * dx + dy * dy + dz * dz;
		if (q == 0)
			return 1'b0;
		len = root_floor(q << 30);
		s   = dx * longint'(cfg_now.normal_x) + dy * longint'(cfg_now.normal_y)
			+ dz * longint'(cfg_now.normal_z);
		mag = (s < 0) ? -s : s;
		qm  = ((mag << 16) + len) / (len << 1);
		dot = (s < 0) ? -longint'(qm) : longint'(qm);
		lo  = -64'sd32768 - longint'(cfg_now.tolerance);
		hi  = -64'sd32768 + longint'(cfg_now.tolerance);
		return (lo <= dot) && (dot <= hi);
	endfunction

	// one accepted cell: add its area (saturating) and, on the last cell of a
	// run, queue the scaled total and clear the sum
	function automatic void accumulate_cell(cell_t c);
		longint unsigned add;
		logic [127:0]    prod;
		add = 0;
		n_cells++;
		if (c.cut) begin
			if (cfg_now.check_normal && !faces_oppose_target(c)) begin
				n_dropped++;
			end else begin
				add = c.area;
				n_summed++;
			end
		end
		area_sum_now += add;
		if (area_sum_now > SUM_MAX)
			area_sum_now = SUM_MAX;
		if (c.last) begin
			prod = 128'(area_sum_now) * 128'(cfg_now.cell_face_area);
			totals_due.push_back((prod[127:64] != 0) ? '1 : prod[63:0]);
			area_sum_now = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [FRAC_W-1:0] random_frac();
		case ($urandom_range(0, 9))
			0, 1:    return '0;
			2, 3:    return FRAC_W'(32768);
			4:       return FRAC_W'($urandom);   // may exceed one, unclamped
			default: return FRAC_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// place a face difference on a pair of opposite faces
	function automatic void split_diff(int d, output logic [FRAC_W-1:0] lo,
			output logic [FRAC_W-1:0] hi);
		int base;
		if (d > 32768)
			d = 32768;
		if (d < -32768)
			d = -32768;
		if (d >= 0) begin
			base = $urandom_range(0, 32768 - d);
			lo   = FRAC_W'(base + d);
			hi   = FRAC_W'(base);
		end else begin
			base = $urandom_range(0, 32768 + d);
			lo   = FRAC_W'(base);
			hi   = FRAC_W'(base - d);
		end
	endfunction

	// difference along one axis that points against the target, with jitter
	function automatic int aligned_diff(logic signed [FRAC_W-1:0] n, int k, int amp);
		return -((int'(n) * k) >>> 15) + int'($urandom_range(0, 2 * amp)) - amp;
	endfunction

	function automatic cell_t random_cell(int unsigned last_odds);
		cell_t             c;
		int                k, amp;
		logic [FRAC_W-1:0] same;
		c.cut = ($urandom_range(0, 9) < 8);
		case ($urandom_range(0, 7))
			0:       c.area = '0;
			1:       c.area = '1;
			default: c.area = FRAC_W'($urandom);
		endcase
		c.last = ($urandom_range(1, last_odds) == 1);
		if (cfg_now.check_normal && $urandom_range(0, 2) != 0) begin
			// well-formed cut: normal close to minus the target, so the
			// filter is exercised near its window edges
			k = $urandom_range(1, 32768);
			case ($urandom_range(0, 3))
				0:       amp = 30;
				1:       amp = 1500;
				default: amp = 0;
			endcase
			split_diff(aligned_diff(cfg_now.normal_x, k, amp), c.x_lo, c.x_hi);
			split_diff(aligned_diff(cfg_now.normal_y, k, amp), c.y_lo, c.y_hi);
			split_diff(aligned_diff(cfg_now.normal_z, k, amp), c.z_lo, c.z_hi);
		end else if ($urandom_range(0, 19) == 0) begin
			// balanced faces, zero-length normal
			same   = random_frac();
			c.x_lo = same;
			c.x_hi = same;
			c.y_lo = same;
			c.y_hi = same;
			c.z_lo = same;
			c.z_hi = same;
		end else begin
			c.x_lo = random_frac();
			c.x_hi = random_frac();
			c.y_lo = random_frac();
			c.y_hi = random_frac();
			c.z_lo = random_frac();
			c.z_hi = random_frac();
		end
		return c;
	endfunction

	// random unit vector in Q1.15
	function automatic void random_normal(output logic signed [FRAC_W-1:0] nx, ny, nz);
		longint          a, b, c;
		longint unsigned len;
		a   = longint'($urandom_range(0, 65534)) - 32767;
		b   = longint'($urandom_range(0, 65534)) - 32767;
		c   = longint'($urandom_range(0, 65534)) - 32767;
		len = root_floor(a * a + b * b + c * c);
		if (len == 0) begin
			c   = 1;
			len = 1;
		end
		nx = FRAC_W'(a * 32767 / longint'(len));
		ny = FRAC_W'(b * 32767 / longint'(len));
		nz = FRAC_W'(c * 32767 / longint'(len));
	endfunction

	// ------------------------------------------------------------------
	// register access
	// ------------------------------------------------------------------
	function automatic logic [DATA_W-1:0] reg_mask(int unsigned idx);
		case (idx)
			REG_CHECK:                   return DATA_W'(1);
			REG_NX, REG_NY, REG_NZ, REG_TOL: return DATA_W'(16'hFFFF);
			REG_CFA:                     return DATA_W'(24'hFF_FFFF);
			default:                     return '0;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(int unsigned idx);
		case (idx)
			REG_CHECK: return DATA_W'(cfg_now.check_normal);
			REG_NX:    return DATA_W'(cfg_now.normal_x);
			REG_NY:    return DATA_W'(cfg_now.normal_y);
			REG_NZ:    return DATA_W'(cfg_now.normal_z);
			REG_TOL:   return DATA_W'(cfg_now.tolerance);
			REG_CFA:   return DATA_W'(cfg_now.cell_face_area);
			default:   return '0;
		endcase
	endfunction

	// setup then access; bits above the field carry junk that must be dropped
	task automatic cfg_write(input int unsigned idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] mask, data;
		mask = reg_mask(idx);
		data = ($urandom & ~mask) | (value & mask);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_CHECK: cfg_now.check_normal   = data[0];
			REG_NX:    cfg_now.normal_x       = data[FRAC_W-1:0];
			REG_NY:    cfg_now.normal_y       = data[FRAC_W-1:0];
			REG_NZ:    cfg_now.normal_z       = data[FRAC_W-1:0];
			REG_TOL:   cfg_now.tolerance      = data[FRAC_W-1:0];
			REG_CFA:   cfg_now.cell_face_area = data[CFA_W-1:0];
			default:   ;
		endcase
	endtask

	task automatic cfg_readback();
		logic [DATA_W-1:0] mask, got;
		for (int i = REG_CHECK; i <= REG_CFA; i++) begin
			mask = reg_mask(i);
			@(posedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= ADDR_W'(i * 4);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			got      = prdata;
			psel    <= 1'b0;
			penable <= 1'b0;
			if ((got & mask) !== (reg_value(i) & mask)) begin
				$display("%0t: register %0d read expected %h got %h",
					$time, i, reg_value(i) & mask, got & mask);
				errors++;
			end
		end
	endtask

	task automatic set_config(input logic chk,
			input logic signed [FRAC_W-1:0] nx, ny, nz,
			input logic [FRAC_W-1:0] tol, input logic [CFA_W-1:0] cfa);
		cfg_write(REG_CHECK, DATA_W'(chk));
		cfg_write(REG_NX,    DATA_W'(nx));
		cfg_write(REG_NY,    DATA_W'(ny));
		cfg_write(REG_NZ,    DATA_W'(nz));
		cfg_write(REG_TOL,   DATA_W'(tol));
		cfg_write(REG_CFA,   DATA_W'(cfa));
		// writes to unused slots must leave everything alone
		cfg_write(SPARE_LO,  $urandom);
		cfg_write(SPARE_HI,  $urandom);
		cfg_readback();
		n_settings++;
	endtask

	// wait for every queued cell to go in and every total to come out, then
	// give a cell that makes no result time to finish
	task automatic settle();
		while (cells_pending.size() != 0 || in_valid || totals_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// cell driver: a transfer completes on valid and not stall; the model
	// sees the cell at that edge. Payload is held while stalled.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				accumulate_cell(cell_q);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (cells_pending.size() != 0) begin
					cell_q   <= cells_pending.pop_front();
					in_valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver stall: random runs, plus one long hold-off during the burst
	// phase so the output register and then the input back up
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_done) begin
				out_stall <= (hold_cnt < HOLD_CYCLES);
				if (hold_cnt == HOLD_CYCLES)
					hold_done <= 1'b1;
				hold_cnt <= hold_cnt + 1;
			end else if (stall_run != 0) begin
				out_stall <= 1'b1;
				stall_run <= stall_run - 1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					stall_run <= pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// result checker: oldest expectation first
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (totals_due.size() == 0) begin
				$display("%0t: total_area expected none got %h", $time, total_area);
				errors++;
			end else begin
				want = totals_due.pop_front();
				if (total_area !== want) begin
					$display("%0t: total_area expected %h got %h", $time, want, total_area);
					errors++;
				end
				n_totals++;
			end
		end
	end

	// watchdog: any transfer on either channel or the register port resets it
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d totals outstanding",
					IDLE_LIMIT, totals_due.size());
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		logic signed [FRAC_W-1:0] nx, ny, nz;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_readback();   // everything comes out of reset at zero

		// plain sum: uncut cells, full-scale area and face area, sum of zero
		set_config(1'b0, '0, '0, '0, '0, '1);
		cells_pending.push_back(cell_t'{1'b0, 16'hFFFF, 16'd32768, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b1});
		cells_pending.push_back(cell_t'{1'b1, 16'h0000, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b1});
		cells_pending.push_back(cell_t'{1'b1, 16'h0001, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
		cells_pending.push_back(cell_t'{1'b0, 16'h1234, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b1});
		settle();

		// target -z, zero tolerance: exact hit, opposite, zero length,
		// fraction beyond one, side-on and diagonal normals
		set_config(1'b1, '0, '0, -16'sd32768, '0, 24'h80_0000);
		cells_pending.push_back(cell_t'{1'b1, 16'd100, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd32768, 16'd0, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'd200, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd32768, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'd300, 16'd32768, 16'd32768,
			16'd32768, 16'd32768, 16'd32768, 16'd32768, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'd400, 16'd0, 16'd0, 16'd0,
			16'd0, 16'hFFFF, 16'd0, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'd500, 16'd32768, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'd600, 16'd32768, 16'd0, 16'd0,
			16'd0, 16'd32768, 16'd0, 1'b1});
		cells_pending.push_back(cell_t'{1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd5,
			16'd5, 16'hFFFF, 16'd1, 1'b1});
		settle();

		// extreme target components, widest tolerance: window edges at +1
		// and just past it on the diagonal
		set_config(1'b1, 16'sd32767, -16'sd32768, '0, 16'hFFFF, 24'd1);
		cells_pending.push_back(cell_t'{1'b1, 16'd7, 16'd32768, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'd9, 16'd0, 16'd32768, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'd11, 16'd0, 16'd0, 16'd32768,
			16'd0, 16'd0, 16'd0, 1'b0});
		cells_pending.push_back(cell_t'{1'b1, 16'd13, 16'd32768, 16'd0, 16'd0,
			16'd32768, 16'd0, 16'd0, 1'b0});
		cells_pending.push_back(cell_t'{1'b0, 16'd15, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b1});
		settle();

		// random phases, each under its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_normal(nx, ny, nz);
			case (p)
				0: set_config(1'b0, FRAC_W'($urandom), FRAC_W'($urandom),
					FRAC_W'($urandom), FRAC_W'($urandom), CFA_W'($urandom));
				1: set_config(1'b1, nx, ny, nz, FRAC_W'($urandom_range(0, 2000)),
					CFA_W'($urandom));
				2: set_config(1'b1, -16'sd32768, '0, '0, '0, '1);
				3: set_config(1'b1, FRAC_W'($urandom), FRAC_W'($urandom),
					FRAC_W'($urandom), FRAC_W'($urandom), CFA_W'($urandom));
				4: set_config(1'b1, nx, ny, nz, 16'hFFFF, '0);
				default: set_config(1'b1, nx, ny, nz, FRAC_W'($urandom_range(50, 600)),
					CFA_W'($urandom));
			endcase
			quiet = (p == 2);
			repeat (PHASE_CELLS) cells_pending.push_back(random_cell(8));
			settle();
		end

		// burst of cheap cells, about half of them last, against a long hold-off
		quiet = 1'b1;
		set_config(1'b0, '0, '0, '0, '0, '1);
		hold_req <= 1'b1;
		repeat (BURST_CELLS) cells_pending.push_back(random_cell(2));
		settle();

		$display("summary: %0d cells over %0d register settings, %0d cut cells summed, %0d filtered out",
			n_cells, n_settings, n_summed, n_dropped);
		$display("summary: %0d totals checked, %0d mismatches", n_totals, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
